@@ hdl/trs_pkg.sv @@
// Package for the trie shortest-root replacer: sizes, codes, memory request types.
// Used by the interfaces and by every module of the block but trs_ram; depends on nothing.
package trs_pkg;

  // trie sizing
  localparam int NODES    = 1024;
  localparam int ALPHABET = 26;
  localparam int NODE_W   = $clog2(NODES);
  localparam int COUNT_W  = $clog2(NODES + 1);
  localparam int SLOT_W   = $clog2(NODES * ALPHABET);
  localparam int IDX_W    = $clog2(ALPHABET);
  // pointer entry: child node plus the root-end mark of that child
  localparam int PTR_W    = NODE_W + 1;

  // beat field widths
  localparam int REQ_W    = 3;
  localparam int LETTER_W = 5;
  localparam int CHAR_W   = 5;

  localparam logic [CHAR_W-1:0] SPACE_CODE = CHAR_W'(26);

  typedef enum logic [REQ_W-1:0] {
    REQ_DICT_LETTER = 3'd0,
    REQ_DICT_END    = 3'd1,
    REQ_SENT_LETTER = 3'd2,
    REQ_SENT_SPACE  = 3'd3,
    REQ_CLEAR       = 3'd4
  } req_e_t;

  typedef enum logic [1:0] {
    MODE_MATCH    = 2'd0,
    MODE_COPY     = 2'd1,
    MODE_SUPPRESS = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_LINK
  } state_t;

  // node table port request (child presence rows)
  typedef struct packed {
    logic                we;
    logic [NODE_W-1:0]   waddr;
    logic [ALPHABET-1:0] wdata;
    logic                re;
    logic [NODE_W-1:0]   raddr;
  } node_req_t;

  // pointer table port request
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [PTR_W-1:0]  wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ptr_req_t;

endpackage

@@ hdl/trs_if.sv @@
// Channel interfaces of the trie shortest-root replacer: request and result beats.
// Depends on trs_pkg for the field widths.
interface trs_req_if;
  import trs_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [LETTER_W-1:0] letter;

  modport source (output valid, output req_type, output letter, input ready);
  modport sink   (input valid, input req_type, input letter, output ready);
endinterface

interface trs_res_if;
  import trs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              dict_full;

  modport source (output valid, output out_char, output dict_full, input ready);
  modport sink   (input valid, input out_char, input dict_full, output ready);
endinterface

@@ hdl/trs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; used for the node table and the pointer table.
module trs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/trs_walker.sv @@
// Walk controller: insert and match walks, node allocation, result register.
// Depends on trs_pkg and trs_if; drives the node and pointer table requests.
module trs_walker (
  input  logic                          clk,
  input  logic                          rst,
  trs_req_if.sink                       req,
  trs_res_if.source                     res,
  output trs_pkg::node_req_t            node_req,
  input  logic [trs_pkg::ALPHABET-1:0]  node_rdata,
  output trs_pkg::ptr_req_t             ptr_req,
  input  logic [trs_pkg::PTR_W-1:0]     ptr_rdata
);
  import trs_pkg::*;

  state_t              state, state_next;

  // walk state
  logic [ALPHABET-1:0] root_present, root_present_next;
  logic [COUNT_W-1:0]  nodes_used, nodes_used_next;
  logic [NODE_W-1:0]   insert_node, insert_node_next;
  logic [SLOT_W-1:0]   insert_slot, insert_slot_next;
  logic                insert_dropped, insert_dropped_next;
  logic [NODE_W-1:0]   match_node, match_node_next;
  mode_t               match_mode, match_mode_next;
  logic                full_flag, full_flag_next;

  // item in flight
  req_e_t              cur_req;
  logic [IDX_W-1:0]    cur_letter;
  logic [NODE_W-1:0]   cur_node;
  logic [SLOT_W-1:0]   cur_slot;
  logic [ALPHABET-1:0] row_hold, row_hold_next;

  // result register
  logic                out_valid, out_valid_next;
  logic [CHAR_W-1:0]   out_char, out_char_next;
  logic                out_full, out_full_next;

  // decode
  logic                accept;
  logic                letter_ok;
  logic                start_lookup;
  logic [NODE_W-1:0]   sel_node;
  logic [SLOT_W-1:0]   sel_slot;
  logic [ALPHABET-1:0] row;
  logic                hit;
  logic                cur_dict;
  logic                pool_full;
  logic                need_link;
  logic                out_free;
  logic                lookup_done;

  assign req.ready     = (state == ST_IDLE);
  assign res.valid     = out_valid;
  assign res.out_char  = out_char;
  assign res.dict_full = out_full;

  // request decode and lookup result
  always_comb begin
    accept    = req.valid && req.ready;
    letter_ok = int'(req.letter) < ALPHABET;
    sel_node  = (req.req_type == REQ_DICT_LETTER) ? insert_node : match_node;
    sel_slot  = SLOT_W'(sel_node) * SLOT_W'(ALPHABET) + SLOT_W'(req.letter);
    start_lookup = 1'b0;
    unique case (req.req_type)
      REQ_DICT_LETTER: start_lookup = accept && letter_ok && !insert_dropped;
      REQ_SENT_LETTER: start_lookup = accept && letter_ok && (match_mode != MODE_SUPPRESS);
      REQ_SENT_SPACE:  start_lookup = accept;
      default:         start_lookup = 1'b0;
    endcase
    row         = (cur_node == '0) ? root_present : node_rdata;
    hit         = row[cur_letter];
    cur_dict    = (cur_req == REQ_DICT_LETTER);
    pool_full   = (nodes_used == COUNT_W'(NODES));
    need_link   = cur_dict && !hit && !pool_full && (cur_node != '0);
    out_free    = !out_valid || res.ready;
    lookup_done = cur_dict || out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_lookup) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_done) begin
          state_next = need_link ? ST_LINK : ST_IDLE;
        end
      end
      ST_LINK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // walk updates and table requests
  always_comb begin
    root_present_next   = root_present;
    nodes_used_next     = nodes_used;
    insert_node_next    = insert_node;
    insert_slot_next    = insert_slot;
    insert_dropped_next = insert_dropped;
    match_node_next     = match_node;
    match_mode_next     = match_mode;
    full_flag_next      = full_flag;
    row_hold_next       = row_hold;
    out_valid_next      = out_valid && !res.ready;
    out_char_next       = out_char;
    out_full_next       = out_full;
    node_req            = '0;
    ptr_req             = '0;

    // both tables are read on every accepted beat
    node_req.re    = accept;
    node_req.raddr = sel_node;
    ptr_req.re     = accept;
    ptr_req.raddr  = sel_slot;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_DICT_END: begin
              // the root end mark lives in the pointer that leads to the node
              if (!insert_dropped && (insert_node != '0)) begin
                ptr_req.we    = 1'b1;
                ptr_req.waddr = insert_slot;
                ptr_req.wdata = {1'b1, insert_node};
              end
              insert_node_next    = '0;
              insert_dropped_next = 1'b0;
            end
            REQ_CLEAR: begin
              root_present_next   = '0;
              nodes_used_next     = COUNT_W'(1);
              insert_node_next    = '0;
              insert_dropped_next = 1'b0;
              match_node_next     = '0;
              match_mode_next     = MODE_MATCH;
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (cur_dict) begin
          priority if (hit) begin
            insert_node_next = ptr_rdata[NODE_W-1:0];
            insert_slot_next = cur_slot;
          end else if (pool_full) begin
            insert_dropped_next = 1'b1;
            full_flag_next      = 1'b1;
          end else begin
            // allocate: link pointer, clear the new row, mark the parent
            ptr_req.we     = 1'b1;
            ptr_req.waddr  = cur_slot;
            ptr_req.wdata  = {1'b0, nodes_used[NODE_W-1:0]};
            node_req.we    = 1'b1;
            node_req.waddr = nodes_used[NODE_W-1:0];
            node_req.wdata = '0;
            if (cur_node == '0) begin
              root_present_next[cur_letter] = 1'b1;
            end
            row_hold_next             = row;
            row_hold_next[cur_letter] = 1'b1;
            insert_node_next          = nodes_used[NODE_W-1:0];
            insert_slot_next          = cur_slot;
            nodes_used_next           = nodes_used + COUNT_W'(1);
          end
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_full_next  = full_flag;
          if (cur_req == REQ_SENT_SPACE) begin
            out_char_next   = SPACE_CODE;
            match_node_next = '0;
            match_mode_next = MODE_MATCH;
          end else begin
            out_char_next = CHAR_W'(cur_letter);
            if (match_mode == MODE_MATCH) begin
              if (hit) begin
                match_node_next = ptr_rdata[NODE_W-1:0];
                if (ptr_rdata[PTR_W-1]) begin
                  match_mode_next = MODE_SUPPRESS;
                end
              end else begin
                match_mode_next = MODE_COPY;
              end
            end
          end
        end
      end
      ST_LINK: begin
        // parent row write-back with the new child bit
        node_req.we    = 1'b1;
        node_req.waddr = cur_node;
        node_req.wdata = row_hold;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      root_present   <= '0;
      nodes_used     <= COUNT_W'(1);
      insert_node    <= '0;
      insert_slot    <= '0;
      insert_dropped <= 1'b0;
      match_node     <= '0;
      match_mode     <= MODE_MATCH;
      full_flag      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      root_present   <= root_present_next;
      nodes_used     <= nodes_used_next;
      insert_node    <= insert_node_next;
      insert_slot    <= insert_slot_next;
      insert_dropped <= insert_dropped_next;
      match_node     <= match_node_next;
      match_mode     <= match_mode_next;
      full_flag      <= full_flag_next;
      out_valid      <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_req    <= req_e_t'(req.req_type);
      cur_letter <= IDX_W'(req.letter);
      cur_node   <= sel_node;
      cur_slot   <= sel_slot;
    end
    row_hold <= row_hold_next;
    out_char <= out_char_next;
    out_full <= out_full_next;
  end

endmodule

@@ hdl/trie_shortest_root_replacer_unit.sv @@
// Top level of the trie shortest-root replacer: walk controller plus two tables.
// Depends on trs_pkg, trs_if, trs_ram and trs_walker.
//
// Usage: request beats arrive on req (req_type, letter) and text beats leave
// on res (out_char, dict_full). Dictionary letters and word ends build a trie
// of roots; sentence letters and spaces produce the rewritten text, one beat
// per echoed letter or space. Clear empties the trie; dict_full stays sticky.
// The req beat is taken in the idle state only. A sentence letter or space
// reads the node and pointer tables in the accept cycle; the walk update then
// loads the result register in the lookup state, once that register is free.
// A dictionary letter passes through the lookup state, and also through the
// link state when it allocates a node under a non-root parent (parent row
// write-back). Word ends, clears, ignored letters and unknown codes stay idle.
// Reset (synchronous, rst high) empties the trie and clears dict_full; no
// clearing pass runs, the block takes beats right after reset. When res is
// stalled, a finished beat waits in the result register; the next request
// is still taken, and a sentence item waits in its lookup until the
// register frees.
module trie_shortest_root_replacer_unit (
  input  logic      clk,
  input  logic      rst,
  trs_req_if.sink   req,
  trs_res_if.source res
);
  import trs_pkg::*;

  node_req_t           node_req;
  ptr_req_t            ptr_req;
  logic [ALPHABET-1:0] node_rdata;
  logic [PTR_W-1:0]    ptr_rdata;

  trs_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res        (res),
    .node_req   (node_req),
    .node_rdata (node_rdata),
    .ptr_req    (ptr_req),
    .ptr_rdata  (ptr_rdata)
  );

  // child presence rows, one per node
  trs_ram #(
    .WIDTH (ALPHABET),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_req.we),
    .waddr (node_req.waddr),
    .wdata (node_req.wdata),
    .re    (node_req.re),
    .raddr (node_req.raddr),
    .rdata (node_rdata)
  );

  // child pointers with the child's root end mark
  trs_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NODES * ALPHABET)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_req.we),
    .waddr (ptr_req.waddr),
    .wdata (ptr_req.wdata),
    .re    (ptr_req.re),
    .raddr (ptr_req.raddr),
    .rdata (ptr_rdata)
  );

endmodule

@@ hdl/trs_checker.sv @@
// Port-level assertions for the trie shortest-root replacer, bound to the top level.
// Depends on trs_pkg for the request and character codes.
module trs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [trs_pkg::REQ_W-1:0]   in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [trs_pkg::CHAR_W-1:0]  out_char,
  input logic                        out_dict_full
);
  import trs_pkg::*;

  // no text beat pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_dict_full))
    else $error("stalled result beat changed");

  // only letters and space are emitted
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char <= SPACE_CODE)
    else $error("result character out of range");

  // a sentence space always goes through the lookup state
  a_space_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_req_type == REQ_SENT_SPACE) |=> !in_ready)
    else $error("request taken during space lookup");

endmodule

bind trie_shortest_root_replacer_unit trs_checker u_trs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .in_req_type   (req.req_type),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .out_char      (res.out_char),
  .out_dict_full (res.dict_full)
);

@@ bench/testbench.sv @@
// Testbench for the trie shortest-root replacer: builds root dictionaries, rewrites
// sentences and checks every text beat against a behavioral trie kept in the bench.
// Depends on trs_pkg, the trs_req_if / trs_res_if channels and the unit under test.
`timescale 1ns / 1ps

module testbench;
  import trs_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              full;
  } text_beat_t;

  logic clk;
  logic rst;

  trs_req_if req_ch ();
  trs_res_if res_ch ();

  trie_shortest_root_replacer_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // shadow trie
  bit [ALPHABET-1:0] kid_mask [NODES];
  bit [NODE_W-1:0]   kid_link [NODES*ALPHABET];
  bit                root_end [NODES];
  int                pool_used = 1;
  int                ins_at    = 0;
  bit                ins_skip  = 0;
  int                walk_at   = 0;
  mode_t             walk_mode = MODE_MATCH;
  bit                full_seen = 0;

  // expected text beats, oldest first
  text_beat_t text_q [$];

  int  error_count  = 0;
  int  live_items   = 0;
  int  beats_seen   = 0;
  int  drop_count   = 0;
  int  clear_count  = 0;
  int  cycle_count  = 0;
  bit  quiet        = 0;
  bit  stalls_off   = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // short gaps mostly, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // update the shadow trie and queue the text beat this request causes
  task automatic trie_apply(input logic [REQ_W-1:0] rt, input logic [LETTER_W-1:0] ltr);
    int         slot;
    bit         fits;
    text_beat_t beat;
    fits = (ltr < ALPHABET);
    case (rt)
      REQ_DICT_LETTER: begin
        if (fits && !ins_skip) begin
          live_items++;
          slot = ins_at * ALPHABET + ltr;
          if (kid_mask[ins_at][ltr]) begin
            ins_at = kid_link[slot];
          end else if (pool_used >= NODES) begin
            // pool exhausted: drop the rest of this word
            ins_skip  = 1;
            full_seen = 1;
            drop_count++;
          end else begin
            kid_mask[pool_used]  = '0;
            root_end[pool_used]  = 0;
            kid_link[slot]       = NODE_W'(pool_used);
            kid_mask[ins_at][ltr] = 1'b1;
            ins_at = pool_used;
            pool_used++;
          end
        end
      end
      REQ_DICT_END: begin
        live_items++;
        if (!ins_skip) root_end[ins_at] = 1;
        ins_at   = 0;
        ins_skip = 0;
      end
      REQ_SENT_LETTER: begin
        if (fits && walk_mode != MODE_SUPPRESS) begin
          live_items++;
          if (walk_mode == MODE_MATCH) begin
            if (kid_mask[walk_at][ltr]) begin
              walk_at = kid_link[walk_at * ALPHABET + ltr];
              if (root_end[walk_at]) walk_mode = MODE_SUPPRESS;
            end else begin
              walk_mode = MODE_COPY;
            end
          end
          beat.ch   = ltr;
          beat.full = full_seen;
          text_q.push_back(beat);
        end
      end
      REQ_SENT_SPACE: begin
        live_items++;
        walk_at   = 0;
        walk_mode = MODE_MATCH;
        beat.ch   = SPACE_CODE;
        beat.full = full_seen;
        text_q.push_back(beat);
      end
      REQ_CLEAR: begin
        live_items++;
        clear_count++;
        kid_mask[0] = '0;
        root_end[0] = 0;
        pool_used   = 1;
        ins_at      = 0;
        ins_skip    = 0;
        walk_at     = 0;
        walk_mode   = MODE_MATCH;
      end
      default: ;
    endcase
  endtask

  // drive one request beat and wait for it to be taken
  task automatic send_request(input logic [REQ_W-1:0] rt, input logic [LETTER_W-1:0] ltr);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.letter   <= ltr;
    do @(posedge clk); while (!req_ch.ready);
    trie_apply(rt, ltr);
  endtask

  // letter from a narrow window most of the time so words share prefixes
  function automatic logic [LETTER_W-1:0] pick_letter(input int base, input int span);
    if (span >= ALPHABET) return LETTER_W'($urandom_range(0, ALPHABET - 1));
    return LETTER_W'(base + $urandom_range(0, span - 1));
  endfunction

  // fixed cases: extremes, every request, ignored codes, clear
  task automatic test_directed();
    send_request(REQ_DICT_LETTER, 5'd0);
    send_request(REQ_DICT_LETTER, 5'd1);
    send_request(REQ_DICT_END, 5'd0);
    send_request(REQ_DICT_LETTER, 5'd25);
    send_request(REQ_DICT_END, 5'd31);
    // empty word marks the root, which never matches
    send_request(REQ_DICT_END, 5'd0);
    send_request(REQ_DICT_LETTER, 5'd26);
    send_request(REQ_DICT_LETTER, 5'd31);
    send_request(3'd5, 5'd0);
    send_request(3'd6, 5'd21);
    send_request(3'd7, 5'd31);
    // hit on a root, then suppressed tail
    send_request(REQ_SENT_LETTER, 5'd0);
    send_request(REQ_SENT_LETTER, 5'd1);
    send_request(REQ_SENT_LETTER, 5'd2);
    send_request(REQ_SENT_SPACE, 5'd0);
    send_request(REQ_SENT_LETTER, 5'd25);
    send_request(REQ_SENT_LETTER, 5'd24);
    send_request(REQ_SENT_SPACE, 5'd31);
    // miss, then copied tail
    send_request(REQ_SENT_LETTER, 5'd2);
    send_request(REQ_SENT_LETTER, 5'd0);
    send_request(REQ_SENT_LETTER, 5'd31);
    send_request(REQ_SENT_LETTER, 5'd26);
    send_request(REQ_SENT_SPACE, 5'd0);
    send_request(REQ_CLEAR, 5'd0);
    send_request(REQ_SENT_LETTER, 5'd0);
    send_request(REQ_SENT_LETTER, 5'd1);
  endtask

  // mostly well-formed dictionary words and sentences, some noise
  task automatic test_random(input int n_items);
    int target;
    int kind;
    int len;
    int words;
    int base;
    int span;
    target = live_items + n_items;
    while (live_items < target) begin
      quiet = ($urandom_range(0, 9) == 0);
      base  = $urandom_range(0, ALPHABET - 4);
      span  = ($urandom_range(0, 4) == 0) ? ALPHABET : 4;
      kind  = $urandom_range(0, 99);
      if (kind < 35) begin
        // dictionary word, now and then empty or left without its end
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        repeat (len) send_request(REQ_DICT_LETTER, pick_letter(base, span));
        if ($urandom_range(0, 19) != 0) send_request(REQ_DICT_END, 5'($urandom_range(0, 31)));
      end else if (kind < 82) begin
        // sentence, no final space
        words = $urandom_range(1, 4);
        for (int w = 0; w < words; w++) begin
          if (w > 0) send_request(REQ_SENT_SPACE, 5'($urandom_range(0, 31)));
          len = $urandom_range(1, 6);
          repeat (len) send_request(REQ_SENT_LETTER, pick_letter(base, span));
        end
      end else if (kind < 85) begin
        send_request(REQ_CLEAR, 5'($urandom_range(0, 31)));
      end else begin
        // noise over the whole field ranges
        len = $urandom_range(1, 4);
        repeat (len) send_request(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
      end
    end
    quiet = 0;
  endtask

  // fill the node pool with one long chain, then check drop and sticky full
  task automatic test_pool_full();
    logic [LETTER_W-1:0] chain [NODES + 2];
    send_request(REQ_CLEAR, 5'd0);
    foreach (chain[i]) chain[i] = LETTER_W'($urandom_range(0, ALPHABET - 1));
    foreach (chain[i]) send_request(REQ_DICT_LETTER, chain[i]);
    send_request(REQ_DICT_END, 5'd0);
    // walk the chain: no roots marked, all echoed
    for (int i = 0; i < 6; i++) send_request(REQ_SENT_LETTER, chain[i]);
    send_request(REQ_SENT_SPACE, 5'd0);
    // a new branch needs a node, so this word is dropped too
    send_request(REQ_DICT_LETTER, chain[0]);
    send_request(REQ_DICT_LETTER, LETTER_W'((chain[1] + 1) % ALPHABET));
    send_request(REQ_DICT_END, 5'd0);
    // an existing prefix still takes its mark
    send_request(REQ_DICT_LETTER, chain[0]);
    send_request(REQ_DICT_LETTER, chain[1]);
    send_request(REQ_DICT_END, 5'd0);
    for (int i = 0; i < 3; i++) send_request(REQ_SENT_LETTER, chain[i]);
    send_request(REQ_SENT_SPACE, 5'd0);
    send_request(REQ_CLEAR, 5'd0);
    send_request(REQ_SENT_LETTER, chain[0]);
    send_request(REQ_SENT_LETTER, chain[1]);
    send_request(REQ_SENT_SPACE, 5'd0);
  endtask

  // result side: random stalls, with calm stretches
  initial begin
    forever begin
      int hold;
      hold = (stalls_off || $urandom_range(0, 7) == 0) ? 0 : pick_gap();
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic report_mismatch(input string what, input text_beat_t want,
                                 input text_beat_t got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch (%s) at cycle %0d: expected char %0d full %0d, got char %0d full %0d",
               what, cycle_count, want.ch, want.full, got.ch, got.full);
  endtask

  // compare each text beat with the oldest expectation
  always @(posedge clk) begin
    text_beat_t got;
    text_beat_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.ch   = res_ch.out_char;
      got.full = res_ch.dict_full;
      beats_seen++;
      if (text_q.size() == 0) begin
        want = '0;
        report_mismatch("no beat expected", want, got);
      end else begin
        want = text_q.pop_front();
        if (got.ch !== want.ch || got.full !== want.full)
          report_mismatch("field", want, got);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count, text_q.size());
      $display("[trie_shortest_root_replacer_unit] ERROR");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_DICT_LETTER;
    req_ch.letter   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(50);
    test_pool_full();
    test_random(20);

    req_ch.valid <= 1'b0;
    while (text_q.size() > 0) @(posedge clk);
    stalls_off = 1;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d effective requests, %0d text beats, %0d clears, %0d words dropped",
             live_items, beats_seen, clear_count, drop_count);
    $display("pool filled to %0d nodes once; %0d mismatches", NODES, error_count);
    if (error_count == 0) begin
      $display("[trie_shortest_root_replacer_unit] OK");
    end else begin
      $display("[trie_shortest_root_replacer_unit] ERROR");
    end
    $finish;
  end

endmodule
